[hdl/fap_pkg.sv]
// Package for the fixed partition allocator.
// Holds the item and result types, operation codes, FSM states and the
// command/status structs shared by the controller, datapath and top level.
package fap_pkg;

	localparam int unsigned SIZE_W  = 12;
	localparam int unsigned INDEX_W = 7;

	typedef enum logic [1:0] {
		OP_APPEND   = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_ALLOCATE = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef struct packed {
		op_t               operation;
		logic [SIZE_W-1:0] partition_size;
		logic [SIZE_W-1:0] request_size;
	} item_t;

	typedef struct packed {
		logic               granted;
		logic [INDEX_W-1:0] partition_index;
		logic [SIZE_W-1:0]  space_left;
		logic               all_occupied;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic finish_simple;
		logic scan_start;
		logic scan_step;
		logic alloc_finish;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  operation;
		logic all_occ;
		logic scan_hit;
		logic scan_last;
	} ctl_sts_t;

endpackage

[hdl/fixed_partition_allocator.sv]
// Top level of the fixed partition allocator.
// Depends on fap_pkg, fap_ctrl, fap_datapath (and fap_ram through it).
//
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and cannot be held off.
// Append, release-all and clear-table go through the decode state and show
// their result from the result register, as does allocate when all are
// occupied. Otherwise allocate scans the size table one entry per cycle through
// the read port of the table RAM, stopping at the first free fitting partition
// of the largest size, else granting the first free fit if any. A new item may
// be started in the cycle done is high. Release-all and clear-table act on the
// occupied marks at once; no clearing pass is needed after reset.
module fixed_partition_allocator #(
	parameter int unsigned MAX_PARTITIONS = 128,
	parameter int unsigned MAX_SIZE_KB    = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  fap_pkg::item_t   item,
	output logic             done,
	output fap_pkg::result_t result
);

	fap_pkg::ctl_cmd_t cmd;
	fap_pkg::ctl_sts_t sts;

	fap_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	fap_datapath #(
		.MAX_PARTITIONS(MAX_PARTITIONS),
		.MAX_SIZE_KB   (MAX_SIZE_KB)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.sts   (sts),
		.done  (done),
		.result(result)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item not held busy");

	a_finish_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_finish |-> (sts.scan_hit || sts.scan_last))
		else $error("allocate finished before scan end");

endmodule

[hdl/fap_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fap_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/fap_ctrl.sv]
// Controller FSM of the fixed partition allocator.
// Depends on fap_pkg for state, command and status types.
module fap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fap_pkg::ctl_sts_t sts,
	output fap_pkg::ctl_cmd_t cmd
);

	fap_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fap_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			fap_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = fap_pkg::ST_DECODE;
				end
			end
			fap_pkg::ST_DECODE: begin
				if (sts.operation == fap_pkg::OP_ALLOCATE && !sts.all_occ) begin
					cmd.scan_start = 1'b1;
					state_d        = fap_pkg::ST_SCAN;
				end else begin
					cmd.finish_simple = 1'b1;
					state_d           = fap_pkg::ST_IDLE;
				end
			end
			fap_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit || sts.scan_last) begin
					cmd.alloc_finish = 1'b1;
					state_d          = fap_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fap_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/fap_datapath.sv]
// Datapath of the fixed partition allocator: size table RAM, occupied marks,
// counters, scan pipeline and result register.
// Depends on fap_pkg and fap_ram.
module fap_datapath #(
	parameter int unsigned MAX_PARTITIONS = 128,
	parameter int unsigned MAX_SIZE_KB    = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fap_pkg::item_t    item,
	input  fap_pkg::ctl_cmd_t cmd,
	output fap_pkg::ctl_sts_t sts,
	output logic              done,
	output fap_pkg::result_t  result
);

	localparam int unsigned AW  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int unsigned CW  = $clog2(MAX_PARTITIONS + 1);
	localparam int unsigned SW  = fap_pkg::SIZE_W;
	localparam int unsigned SAT = (MAX_SIZE_KB > (2 ** SW) - 1) ? (2 ** SW) - 1 : MAX_SIZE_KB;
	localparam logic [SW-1:0] SAT_SIZE  = SAT[SW-1:0];
	localparam logic [CW-1:0] MAX_COUNT = MAX_PARTITIONS[CW-1:0];
	localparam logic [CW-1:0] ONE       = CW'(1);

	fap_pkg::item_t          item_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           occ_count_q;
	logic [SW-1:0]           largest_q;
	logic [MAX_PARTITIONS-1:0] occ_q;

	logic [CW-1:0]           rd_idx_q;
	logic [CW-1:0]           idx_s1;
	logic                    valid_s1;
	logic                    have_first_q;
	logic [CW-1:0]           first_idx_q;
	logic [SW-1:0]           first_size_q;

	logic                    done_q;
	fap_pkg::result_t        result_q;
	fap_pkg::result_t        result_d;

	logic                    ram_we;
	logic [SW-1:0]           psize_sat;
	logic                    ram_re;
	logic [SW-1:0]           rd_data;

	logic                    cur_fit;
	logic                    cur_hit;
	logic                    scan_last;
	logic                    pick_valid;
	logic [CW-1:0]           pick_idx;
	logic [SW-1:0]           pick_size;

	assign psize_sat = (item_q.partition_size > SAT_SIZE) ? SAT_SIZE : item_q.partition_size;
	assign ram_we    = cmd.finish_simple && item_q.operation == fap_pkg::OP_APPEND
	                   && count_q < MAX_COUNT;
	assign ram_re    = cmd.scan_step;

	fap_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_PARTITIONS)
	) u_size_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(psize_sat),
		.re   (ram_re),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	assign cur_fit   = valid_s1 && !occ_q[idx_s1[AW-1:0]] && item_q.request_size <= rd_data;
	assign cur_hit   = cur_fit && rd_data == largest_q;
	assign scan_last = valid_s1 && idx_s1 == count_q - ONE;

	always_comb begin
		pick_valid = 1'b0;
		pick_idx   = idx_s1;
		pick_size  = rd_data;
		priority if (cur_hit) begin
			pick_valid = 1'b1;
		end else if (have_first_q) begin
			pick_valid = 1'b1;
			pick_idx   = first_idx_q;
			pick_size  = first_size_q;
		end else if (cur_fit) begin
			pick_valid = 1'b1;
		end
	end

	assign sts.operation = item_q.operation;
	assign sts.all_occ   = occ_count_q == count_q;
	assign sts.scan_hit  = cur_hit;
	assign sts.scan_last = scan_last;

	always_comb begin
		result_d = '0;
		if (cmd.alloc_finish) begin
			if (pick_valid) begin
				result_d.granted         = 1'b1;
				result_d.partition_index = fap_pkg::INDEX_W'(pick_idx);
				result_d.space_left      = pick_size - item_q.request_size;
				result_d.all_occupied    = occ_count_q + ONE == count_q;
			end else begin
				result_d.all_occupied    = occ_count_q == count_q;
			end
		end else begin
			unique case (item_q.operation)
				fap_pkg::OP_APPEND: begin
					if (count_q < MAX_COUNT) begin
						result_d.granted         = 1'b1;
						result_d.partition_index = fap_pkg::INDEX_W'(count_q);
						result_d.all_occupied    = occ_count_q == count_q + ONE;
					end else begin
						result_d.all_occupied    = occ_count_q == count_q;
					end
				end
				fap_pkg::OP_RELEASE: begin
					result_d.all_occupied = count_q == '0;
				end
				fap_pkg::OP_ALLOCATE: begin
					result_d.all_occupied = occ_count_q == count_q;
				end
				fap_pkg::OP_CLEAR: begin
					result_d.all_occupied = 1'b1;
				end
				default: begin
					result_d.all_occupied = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.scan_step) begin
			idx_s1 <= rd_idx_q;
		end
		if (cmd.scan_step && cur_fit && !have_first_q) begin
			first_idx_q  <= idx_s1;
			first_size_q <= rd_data;
		end
		if (cmd.finish_simple || cmd.alloc_finish) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			occ_count_q  <= '0;
			largest_q    <= '0;
			occ_q        <= '0;
			rd_idx_q     <= '0;
			valid_s1     <= 1'b0;
			have_first_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.finish_simple || cmd.alloc_finish;
			if (cmd.finish_simple) begin
				unique case (item_q.operation)
					fap_pkg::OP_APPEND: begin
						if (count_q < MAX_COUNT) begin
							occ_q[count_q[AW-1:0]] <= 1'b0;
							count_q                <= count_q + ONE;
							if (psize_sat > largest_q) begin
								largest_q <= psize_sat;
							end
						end
					end
					fap_pkg::OP_RELEASE: begin
						occ_q       <= '0;
						occ_count_q <= '0;
					end
					fap_pkg::OP_ALLOCATE: begin
					end
					fap_pkg::OP_CLEAR: begin
						occ_q       <= '0;
						occ_count_q <= '0;
						count_q     <= '0;
						largest_q   <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan_start) begin
				rd_idx_q     <= '0;
				valid_s1     <= 1'b0;
				have_first_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				valid_s1 <= rd_idx_q < count_q;
				if (rd_idx_q < count_q) begin
					rd_idx_q <= rd_idx_q + ONE;
				end
				if (cur_fit) begin
					have_first_q <= 1'b1;
				end
			end
			if (cmd.alloc_finish && pick_valid) begin
				occ_q[pick_idx[AW-1:0]] <= 1'b1;
				occ_count_q             <= occ_count_q + ONE;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
